/* hw/rtl/gspb_pkg.sv */
`default_nettype none

package gspb_pkg;

    // Exponential lookup table size and the widths that follow from it
    localparam int EXP_TABLE_ENTRIES = 256;
    localparam int IDX_W  = $clog2(EXP_TABLE_ENTRIES);
    localparam int SPAN_W = $clog2(EXP_TABLE_ENTRIES);
    localparam logic [SPAN_W-1:0] EXP_SPAN = SPAN_W'(EXP_TABLE_ENTRIES - 1);

    // Quadratic form S = xx*dx^2 + 2*xy*dx*dy + yy*dy^2, q = S / 2^31
    localparam int S_W  = 46;
    localparam int SC_W = 35;
    localparam logic [SC_W:0] Q_LIMIT = (SC_W + 1)'(36'd9 << 31);

    // Index = floor(floor(S * span / 2^31) / 9), the /9 by reciprocal
    localparam int U_W      = $clog2(9 * EXP_TABLE_ENTRIES);
    localparam int RECIP_SH = 20;
    localparam int RECIP_W  = 17;
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((2 ** RECIP_SH + 8) / 9);

    // Alpha in Q.24
    localparam int ROM_W   = 17;
    localparam int OP_W    = 9;
    localparam int ALPHA_W = 25;
    localparam logic [ALPHA_W-1:0] ALPHA_MIN = ALPHA_W'(67109);
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << 24);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef logic [ROM_W-1:0] t_exp_rom [EXP_TABLE_ENTRIES];

    // exp(-9i/span) in Q1.16, built from a Q0.31 Taylor series of the step ratio
    function automatic t_exp_rom build_exp_rom();
        t_exp_rom   rom;
        longint unsigned x;
        longint unsigned term;
        longint unsigned r;
        longint unsigned p;
        x    = 64'(Q_LIMIT) / 64'(EXP_SPAN);
        term = 64'd1 << 31;
        r    = term;
        p    = 64'd1 << 31;
        for (int n = 1; n <= 16; n++) begin
            term = ((term * x) >> 31) / 64'(n);
            if (n % 2 == 1) begin
                r = r - term;
            end else begin
                r = r + term;
            end
        end
        for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
            rom[i] = ROM_W'((p + (64'd1 << 14)) >> 15);
            p      = (p * r + (64'd1 << 30)) >> 31;
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = build_exp_rom();

    // One classified pixel between front and back
    typedef struct packed {
        logic                skip;
        logic [26:0]         dxx;
        logic signed [27:0]  dxy;
        logic [26:0]         dyy;
        logic [15:0]         cxx;
        logic signed [16:0]  cxy;
        logic [15:0]         cyy;
        logic [OP_W-1:0]     op;
        logic [15:0]         fg;
        logic [15:0]         bg;
    } t_gspb_entry;

endpackage

`default_nettype wire

/* hw/rtl/gspb_front.sv */
`default_nettype none

module gspb_front
    import gspb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_depth_test_enable,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [13:0] i_offset_x,
    input  wire logic signed [13:0] i_offset_y,
    input  wire logic [15:0]        i_conic_xx,
    input  wire logic signed [16:0] i_conic_xy,
    input  wire logic [15:0]        i_conic_yy,
    input  wire logic [8:0]         i_opacity,
    input  wire logic [15:0]        i_splat_color,
    input  wire logic [15:0]        i_background_pixel,
    input  wire logic [15:0]        i_stored_depth,
    input  wire logic [15:0]        i_splat_depth,
    output logic                    o_q_valid,
    input  wire logic               i_q_ready,
    output t_gspb_entry             o_entry
);

    logic        r_valid;
    t_gspb_entry r_entry;
    t_gspb_entry n_entry;
    logic        load;
    logic signed [27:0] sq_x;
    logic signed [27:0] sq_y;

    assign load    = !r_valid || i_q_ready;
    assign o_stall = !load;

    always_comb begin
        sq_x          = i_offset_x * i_offset_x;
        sq_y          = i_offset_y * i_offset_y;
        n_entry.skip  = i_depth_test_enable && (i_stored_depth > i_splat_depth);
        n_entry.dxx   = sq_x[26:0];
        n_entry.dxy   = i_offset_x * i_offset_y;
        n_entry.dyy   = sq_y[26:0];
        n_entry.cxx   = i_conic_xx;
        n_entry.cxy   = i_conic_xy;
        n_entry.cyy   = i_conic_yy;
        n_entry.op    = i_opacity;
        n_entry.fg    = i_splat_color;
        n_entry.bg    = i_background_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_entry <= n_entry;
        end
    end

    assign o_q_valid = r_valid;
    assign o_entry   = r_entry;

endmodule

`default_nettype wire

/* hw/rtl/gspb_queue.sv */
`default_nettype none

module gspb_queue
    import gspb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  t_gspb_entry i_entry,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_gspb_entry o_entry
);

    t_gspb_entry       r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              push;
    logic              pop;

    assign o_ready = (r_count != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_entry = r_mem[r_rd_ptr];

    // Depth is a power of two: pointers wrap on their own
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue lost a beat on push");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !push |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count wrong on pop");

endmodule

`default_nettype wire

/* hw/rtl/gspb_back.sv */
`default_nettype none

module gspb_back
    import gspb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  t_gspb_entry i_entry,
    output logic        o_valid,
    input  wire logic   i_stall,
    output logic [15:0] o_pixel_out,
    output logic        o_pixel_written
);

    // Stage valids and advance enables
    logic r_va, r_vb, r_vc, r_vd, r_ve, r_vf, r_vg, r_vh;
    logic adv_a, adv_b, adv_c, adv_d, adv_e, adv_f, adv_g, adv_h;

    // Payload carried along
    logic r_a_skip, r_b_skip, r_c_skip, r_d_skip, r_e_skip, r_f_skip;
    logic [OP_W-1:0] r_a_op, r_b_op, r_c_op, r_d_op, r_e_op;
    logic [15:0] r_a_fg, r_b_fg, r_c_fg, r_d_fg, r_e_fg, r_f_fg;
    logic [15:0] r_a_bg, r_b_bg, r_c_bg, r_d_bg, r_e_bg, r_f_bg, r_g_bg;

    logic [42:0]         r_a_xx;
    logic signed [44:0]  r_a_xy;
    logic [42:0]         r_a_yy;
    logic [SC_W-1:0]     r_b_sc;
    logic [U_W-1:0]      r_c_u;
    logic [IDX_W-1:0]    r_d_idx;
    logic [ROM_W-1:0]    r_e_rom;
    logic [ALPHA_W-1:0]  r_f_alpha;
    logic                r_g_written;
    logic [ALPHA_W-1:0]  r_g_acl;
    logic signed [31:0]  r_g_pr, r_g_pg, r_g_pb;
    logic [15:0]         r_h_pixel;
    logic                r_h_written;

    logic signed [S_W-1:0]      s_sum;
    logic                       s_neg;
    logic                       s_in_range;
    logic [SC_W+SPAN_W-1:0]     c_prod;
    logic [U_W+RECIP_W-1:0]     d_prod;
    logic [IDX_W:0]             d_raw;
    logic [IDX_W-1:0]           d_idx;
    logic                       g_written;
    logic [ALPHA_W-1:0]         g_acl;
    logic signed [31:0]         g_a32;
    logic signed [5:0]          g_dr, g_db;
    logic signed [6:0]          g_dg;
    logic signed [31:0]         g_dr32, g_dg32, g_db32;
    logic signed [6:0]          h_tr, h_tg, h_tb;
    logic [6:0]                 h_sr, h_sg, h_sb;
    logic [15:0]                h_pixel;

    // Round half up, then truncate toward zero: (prod + 2^23) / 2^24
    function automatic logic signed [6:0] round_step(input logic signed [31:0] prod);
        logic signed [31:0] num;
        logic [31:0]        mag;
        logic [6:0]         tm;
        num = prod + 32'sd8388608;
        mag = num[31] ? 32'(-num) : 32'(num);
        tm  = mag[30:24];
        return num[31] ? -$signed(tm) : $signed(tm);
    endfunction

    assign adv_h   = !r_vh || !i_stall;
    assign adv_g   = !r_vg || adv_h;
    assign adv_f   = !r_vf || adv_g;
    assign adv_e   = !r_ve || adv_f;
    assign adv_d   = !r_vd || adv_e;
    assign adv_c   = !r_vc || adv_d;
    assign adv_b   = !r_vb || adv_c;
    assign adv_a   = !r_va || adv_b;
    assign o_ready = adv_a;

    always_comb begin
        s_sum      = $signed({3'b000, r_a_xx}) + $signed({r_a_xy, 1'b0})
                   + $signed({3'b000, r_a_yy});
        s_neg      = s_sum[S_W-1];
        s_in_range = s_neg || (s_sum[S_W-2:0] < (S_W - 1)'(Q_LIMIT));

        c_prod = (SC_W + SPAN_W)'(r_b_sc) * (SC_W + SPAN_W)'(EXP_SPAN);

        d_prod = (U_W + RECIP_W)'(r_c_u) * (U_W + RECIP_W)'(RECIP_9);
        d_raw  = d_prod[RECIP_SH +: IDX_W + 1];
        d_idx  = (d_raw > (IDX_W + 1)'(EXP_SPAN)) ? IDX_W'(EXP_SPAN) : d_raw[IDX_W-1:0];

        g_written = !r_f_skip && (r_f_alpha >= ALPHA_MIN);
        g_acl     = (r_f_alpha > ALPHA_ONE) ? ALPHA_ONE : r_f_alpha;
        g_a32     = $signed(32'(g_acl));
        g_dr      = $signed({1'b0, r_f_fg[15:11]}) - $signed({1'b0, r_f_bg[15:11]});
        g_dg      = $signed({1'b0, r_f_fg[10:5]}) - $signed({1'b0, r_f_bg[10:5]});
        g_db      = $signed({1'b0, r_f_fg[4:0]}) - $signed({1'b0, r_f_bg[4:0]});
        g_dr32    = 32'(g_dr);
        g_dg32    = 32'(g_dg);
        g_db32    = 32'(g_db);

        h_tr    = round_step(r_g_pr);
        h_tg    = round_step(r_g_pg);
        h_tb    = round_step(r_g_pb);
        h_sr    = 7'({2'b00, r_g_bg[15:11]}) + 7'(h_tr);
        h_sg    = 7'({1'b0, r_g_bg[10:5]}) + 7'(h_tg);
        h_sb    = 7'({2'b00, r_g_bg[4:0]}) + 7'(h_tb);
        h_pixel = r_g_written ? {h_sr[4:0], h_sg[5:0], h_sb[4:0]} : r_g_bg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
            r_vg <= 1'b0;
            r_vh <= 1'b0;
        end else begin
            if (adv_a) r_va <= i_valid;
            if (adv_b) r_vb <= r_va;
            if (adv_c) r_vc <= r_vb;
            if (adv_d) r_vd <= r_vc;
            if (adv_e) r_ve <= r_vd;
            if (adv_f) r_vf <= r_ve;
            if (adv_g) r_vg <= r_vf;
            if (adv_h) r_vh <= r_vg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_a_xx   <= 43'(i_entry.cxx) * 43'(i_entry.dxx);
            r_a_xy   <= $signed(i_entry.cxy) * $signed(i_entry.dxy);
            r_a_yy   <= 43'(i_entry.cyy) * 43'(i_entry.dyy);
            r_a_skip <= i_entry.skip;
            r_a_op   <= i_entry.op;
            r_a_fg   <= i_entry.fg;
            r_a_bg   <= i_entry.bg;
        end
        if (adv_b) begin
            // Indefinite conic: treat negative q as zero
            r_b_sc   <= s_neg ? '0 : s_sum[SC_W-1:0];
            r_b_skip <= r_a_skip || !s_in_range;
            r_b_op   <= r_a_op;
            r_b_fg   <= r_a_fg;
            r_b_bg   <= r_a_bg;
        end
        if (adv_c) begin
            r_c_u    <= c_prod[31 +: U_W];
            r_c_skip <= r_b_skip;
            r_c_op   <= r_b_op;
            r_c_fg   <= r_b_fg;
            r_c_bg   <= r_b_bg;
        end
        if (adv_d) begin
            r_d_idx  <= d_idx;
            r_d_skip <= r_c_skip;
            r_d_op   <= r_c_op;
            r_d_fg   <= r_c_fg;
            r_d_bg   <= r_c_bg;
        end
        if (adv_e) begin
            r_e_rom  <= EXP_ROM[r_d_idx];
            r_e_skip <= r_d_skip;
            r_e_op   <= r_d_op;
            r_e_fg   <= r_d_fg;
            r_e_bg   <= r_d_bg;
        end
        if (adv_f) begin
            r_f_alpha <= ALPHA_W'(r_e_op) * ALPHA_W'(r_e_rom);
            r_f_skip  <= r_e_skip;
            r_f_fg    <= r_e_fg;
            r_f_bg    <= r_e_bg;
        end
        if (adv_g) begin
            r_g_written <= g_written;
            r_g_acl     <= g_acl;
            r_g_pr      <= g_dr32 * g_a32;
            r_g_pg      <= g_dg32 * g_a32;
            r_g_pb      <= g_db32 * g_a32;
            r_g_bg      <= r_f_bg;
        end
        if (adv_h) begin
            r_h_pixel   <= h_pixel;
            r_h_written <= r_g_written;
        end
    end

    assign o_valid         = r_vh;
    assign o_pixel_out     = r_h_pixel;
    assign o_pixel_written = r_h_written;

    a_hold_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_va && !adv_b |=> r_va)
        else $error("first stage dropped a beat under back-pressure");

    // Out-of-range forms are skipped and carry a truncated value
    a_u_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vc && !r_c_skip |-> r_c_u < U_W'(9 * (EXP_TABLE_ENTRIES - 1)))
        else $error("scaled form out of table range");

    a_alpha_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vg && r_g_written |-> r_g_acl <= ALPHA_ONE && r_g_acl >= ALPHA_MIN)
        else $error("blend alpha outside its range");

endmodule

`default_nettype wire

/* hw/rtl/gaussian_splat_pixel_blend_top.sv */
// Path: an accepted input beat passes one front register, one queue slot and eight back
// stages before its result beat leaves.
// Throughput: one pixel per clock while the output is not stalled; a 4-beat queue lets
// the front keep accepting while the back is held by the output stall, until the queue fills.
// Reset: synchronous, active low; clears all valids, the queue and depth_test_enable.
`default_nettype none

module gaussian_splat_pixel_blend_top
    import gspb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [13:0] i_offset_x,
    input  wire logic signed [13:0] i_offset_y,
    input  wire logic [15:0]        i_conic_xx,
    input  wire logic signed [16:0] i_conic_xy,
    input  wire logic [15:0]        i_conic_yy,
    input  wire logic [8:0]         i_opacity,
    input  wire logic [15:0]        i_splat_color,
    input  wire logic [15:0]        i_background_pixel,
    input  wire logic [15:0]        i_stored_depth,
    input  wire logic [15:0]        i_splat_depth,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [15:0]             o_pixel_out,
    output logic                    o_pixel_written
);

    logic        r_depth_test_enable;
    logic        fq_valid;
    logic        fq_ready;
    t_gspb_entry fq_entry;
    logic        qb_valid;
    logic        qb_ready;
    t_gspb_entry qb_entry;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_test_enable <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_depth_test_enable <= i_cfg_data;
        end
    end

    gspb_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_depth_test_enable (r_depth_test_enable),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_offset_x          (i_offset_x),
        .i_offset_y          (i_offset_y),
        .i_conic_xx          (i_conic_xx),
        .i_conic_xy          (i_conic_xy),
        .i_conic_yy          (i_conic_yy),
        .i_opacity           (i_opacity),
        .i_splat_color       (i_splat_color),
        .i_background_pixel  (i_background_pixel),
        .i_stored_depth      (i_stored_depth),
        .i_splat_depth       (i_splat_depth),
        .o_q_valid           (fq_valid),
        .i_q_ready           (fq_ready),
        .o_entry             (fq_entry)
    );

    gspb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_entry (fq_entry),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_entry (qb_entry)
    );

    gspb_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (qb_valid),
        .o_ready         (qb_ready),
        .i_entry         (qb_entry),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_out     (o_pixel_out),
        .o_pixel_written (o_pixel_written)
    );

endmodule

`default_nettype wire
